>>> hw/rtl/grid_line_of_sight_ray_top_assert.svh
// assertion macros for the line-of-sight ray rtl
// no dependencies; included inside glos_walker, which checks its own logic
`ifndef GRID_LINE_OF_SIGHT_RAY_TOP_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_RAY_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GLOS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glos assertion failed");

// next-cycle implication, checked out of reset
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glos assertion failed");

`endif

>>> hw/rtl/glos_pkg.sv
// types and constants of the grid line-of-sight ray block
// no dependencies; imported by every rtl module of the block
package glos_pkg;

  localparam int unsigned CoordW   = 5;
  localparam int unsigned StepW    = 6;
  localparam int unsigned ErrW     = 8;
  localparam int unsigned WallW    = 32;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 16;

  // input tdata field offsets, lowest first
  localparam int unsigned RowIdxLsb = 0;
  localparam int unsigned WallsLsb  = RowIdxLsb + CoordW;
  localparam int unsigned OrgXLsb   = WallsLsb + WallW;
  localparam int unsigned OrgYLsb   = OrgXLsb + CoordW;
  localparam int unsigned TgtXLsb   = OrgYLsb + CoordW;
  localparam int unsigned TgtYLsb   = TgtXLsb + CoordW;
  localparam int unsigned InUsedW   = TgtYLsb + CoordW;

  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_TRACE = 1'b1
  } func_e;

  // one walked cell on its way from the walker to the output stage
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   in_grid;
    logic   first;
    logic   last;
    logic   force_vis;
  } cell_t;

endpackage

>>> hw/rtl/glos_wall_mem.sv
// wall bitmap memory: one row per entry, one write and one registered read port
// depends on glos_pkg; row valid flags make unwritten rows read as no walls
module glos_wall_mem #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [$clog2(GRID_SIZE)-1:0]  wr_addr_i,
  input  logic [GRID_SIZE-1:0]          wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(GRID_SIZE)-1:0]  rd_addr_i,
  output logic [GRID_SIZE-1:0]          rd_data_o
);
  import glos_pkg::*;

  logic [GRID_SIZE-1:0] mem_q [GRID_SIZE];
  logic [GRID_SIZE-1:0] rd_data_q;
  logic [GRID_SIZE-1:0] row_valid_q;
  logic                 rd_valid_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // row valid flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

>>> hw/rtl/glos_walker.sv
// ray walker: sets up the doubled error term and steps one cell per cycle while the output stage takes cells
// depends on glos_pkg and the assertion macro header
module glos_walker #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             reveal_all_i,
  input  glos_pkg::coord_t origin_x_i,
  input  glos_pkg::coord_t origin_y_i,
  input  glos_pkg::coord_t target_x_i,
  input  glos_pkg::coord_t target_y_i,
  output logic             busy_o,
  output logic             cell_valid_o,
  input  logic             cell_ready_i,
  output glos_pkg::cell_t  cell_o
);
  import glos_pkg::*;

  logic                    busy_q, busy_d;
  coord_t                  walk_x_q, walk_x_d;
  coord_t                  walk_y_q, walk_y_d;
  coord_t                  dx_q, dx_d;
  coord_t                  dy_q, dy_d;
  logic                    x_up_q, x_up_d;
  logic                    y_up_q, y_up_d;
  logic signed [ErrW-1:0]  err_q, err_d;
  logic [StepW-1:0]        steps_q, steps_d;
  logic                    first_q, first_d;
  logic                    force_q, force_d;

  logic                    x_gt, y_gt;
  coord_t                  dx_new, dy_new;
  logic signed [ErrW-1:0]  two_dx, two_dy;
  logic                    step_go;

  // setup arithmetic from the accepted trace word
  assign x_gt   = target_x_i > origin_x_i;
  assign y_gt   = target_y_i > origin_y_i;
  assign dx_new = x_gt ? (target_x_i - origin_x_i) : (origin_x_i - target_x_i);
  assign dy_new = y_gt ? (target_y_i - origin_y_i) : (origin_y_i - target_y_i);
  assign two_dx = $signed({2'b00, dx_q, 1'b0});
  assign two_dy = $signed({2'b00, dy_q, 1'b0});
  assign step_go = busy_q && cell_ready_i;

  // next walk state
  always_comb begin
    busy_d   = busy_q;
    walk_x_d = walk_x_q;
    walk_y_d = walk_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    x_up_d   = x_up_q;
    y_up_d   = y_up_q;
    err_d    = err_q;
    steps_d  = steps_q;
    first_d  = first_q;
    force_d  = force_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      x_up_d  = x_gt;
      y_up_d  = y_gt;
      if (reveal_all_i) begin
        walk_x_d = target_x_i;
        walk_y_d = target_y_i;
        dx_d     = '0;
        dy_d     = '0;
        err_d    = '0;
        steps_d  = StepW'(1);
        force_d  = 1'b1;
      end else begin
        walk_x_d = origin_x_i;
        walk_y_d = origin_y_i;
        dx_d     = dx_new;
        dy_d     = dy_new;
        err_d    = $signed({3'b000, dx_new}) - $signed({3'b000, dy_new});
        steps_d  = StepW'({1'b0, dx_new}) + StepW'({1'b0, dy_new}) + StepW'(1);
        force_d  = 1'b0;
      end
    end else if (step_go) begin
      first_d = 1'b0;
      if (steps_q == StepW'(1)) begin
        busy_d = 1'b0;
      end else begin
        steps_d = steps_q - StepW'(1);
        if (err_q > $signed(ErrW'(0))) begin
          walk_x_d = x_up_q ? (walk_x_q + CoordW'(1)) : (walk_x_q - CoordW'(1));
          err_d    = err_q - two_dy;
        end else begin
          walk_y_d = y_up_q ? (walk_y_q + CoordW'(1)) : (walk_y_q - CoordW'(1));
          err_d    = err_q + two_dx;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      steps_q <= '0;
      err_q   <= '0;
      walk_x_q <= '0;
      walk_y_q <= '0;
    end else begin
      busy_q   <= busy_d;
      steps_q  <= steps_d;
      err_q    <= err_d;
      walk_x_q <= walk_x_d;
      walk_y_q <= walk_y_d;
    end
  end

  // per-ray operands
  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    x_up_q  <= x_up_d;
    y_up_q  <= y_up_d;
    first_q <= first_d;
    force_q <= force_d;
  end

  // cell handed to the output stage
  always_comb begin
    cell_o.x         = walk_x_q;
    cell_o.y         = walk_y_q;
    cell_o.in_grid   = ({1'b0, walk_x_q} < StepW'(GRID_SIZE)) &&
                       ({1'b0, walk_y_q} < StepW'(GRID_SIZE));
    cell_o.first     = first_q;
    cell_o.last      = steps_q == StepW'(1);
    cell_o.force_vis = force_q;
  end

  assign cell_valid_o = busy_q;
  assign busy_o       = busy_q;

`include "grid_line_of_sight_ray_top_assert.svh"

  `GLOS_ASSERT_NOW(a_busy_has_steps, clk_i, rst_ni, busy_q, steps_q != '0)
  `GLOS_ASSERT_NEXT(a_reveal_one_cell, clk_i, rst_ni, start_i && reveal_all_i,
                    busy_q && steps_q == StepW'(1) && force_q)
  `GLOS_ASSERT_NOW(a_err_bounded, clk_i, rst_ni, busy_q,
                   (err_q <= two_dx) && (err_q >= -two_dy))
  `GLOS_ASSERT_NEXT(a_last_ends_walk, clk_i, rst_ni, step_go && cell_o.last, !busy_q)

endmodule

>>> hw/rtl/glos_vis_out.sv
// visibility stage and output register: applies the wall bit and first-wall rule
// depends on glos_pkg; wall row comes from glos_wall_mem the cycle after the read
module glos_vis_out #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cell_valid_i,
  output logic                    cell_ready_o,
  input  glos_pkg::cell_t         cell_i,
  input  logic [GRID_SIZE-1:0]    wall_row_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output glos_pkg::coord_t        cell_x_o,
  output glos_pkg::coord_t        cell_y_o,
  output logic                    visible_o,
  output logic                    last_cell_o
);
  import glos_pkg::*;

  localparam int unsigned AddrW = $clog2(GRID_SIZE);

  logic    m_valid_q;
  cell_t   m_cell_q;
  logic    out_valid_q;
  coord_t  out_x_q;
  coord_t  out_y_q;
  logic    out_vis_q;
  logic    out_last_q;
  logic    wall_seen_q, wall_seen_d;

  logic    out_free;
  logic    m_move;
  logic    seen_eff;
  logic    is_wall;
  logic    vis;

  assign out_free     = !out_valid_q || out_ready_i;
  assign m_move       = m_valid_q && out_free;
  assign cell_ready_o = !m_valid_q || out_free;

  // wall verdict for the cell waiting on its memory row
  assign is_wall     = m_cell_q.in_grid && wall_row_i[m_cell_q.x[AddrW-1:0]];
  assign seen_eff    = m_cell_q.first ? 1'b0 : wall_seen_q;
  assign vis         = m_cell_q.force_vis || !seen_eff;
  assign wall_seen_d = seen_eff || is_wall;

  // valid flags and first-wall tracker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      wall_seen_q <= 1'b0;
    end else begin
      if (cell_ready_o) begin
        m_valid_q <= cell_valid_i;
      end
      if (out_free) begin
        out_valid_q <= m_valid_q;
      end
      if (m_move) begin
        wall_seen_q <= wall_seen_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cell_ready_o && cell_valid_i) begin
      m_cell_q <= cell_i;
    end
    if (m_move) begin
      out_x_q    <= m_cell_q.x;
      out_y_q    <= m_cell_q.y;
      out_vis_q  <= vis;
      out_last_q <= m_cell_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_x_o    = out_x_q;
  assign cell_y_o    = out_y_q;
  assign visible_o   = out_vis_q;
  assign last_cell_o = out_last_q;

endmodule

>>> hw/rtl/grid_line_of_sight_ray_top.sv
// top level of the grid line-of-sight ray block
// depends on glos_pkg, glos_wall_mem, glos_walker and glos_vis_out
//
// usage:
// - the slave stream takes one word per item; tuser 0 loads one wall row,
//   tuser 1 traces a ray from the origin cell to the target cell
// - the master stream gives one word per visited cell, origin first; tlast
//   marks the target cell, tuser is the visible flag
// - the config channel writes reveal_all; with it set a trace gives only the
//   target cell, visible
// - a load word gives no output
// - a trace holds the slave side until the walker has issued its last cell:
//   the walker issues one cell and one wall-row read per cycle while the
//   output stage takes cells, so a ray gives 1+|dx|+|dy| cells, 1 to 63
// - the first cell passes the walker, the wall-row read and the output
//   register before it appears on the master side
// - when the master side stalls, the walker and the memory read hold; the
//   next word is taken as soon as the walker has issued its last cell
// - reset clears reveal_all and marks every wall row empty at once
module grid_line_of_sight_ray_top #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // row_index, row_walls, origin_x, origin_y, target_x, target_y, zero pad
  input  logic [glos_pkg::InDataW-1:0]   s_axis_tdata_i,
  // func
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // cell_x, cell_y, zero pad
  output logic [glos_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // visible
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i
);
  import glos_pkg::*;

  localparam int unsigned AddrW = $clog2(GRID_SIZE);

  logic                 reveal_all_q;
  logic                 in_fire;
  logic                 load_row;
  logic                 start_trace;
  logic                 walker_busy;
  logic                 cell_valid;
  logic                 cell_ready;
  cell_t                walk_cell;
  logic [GRID_SIZE-1:0] wall_row;
  coord_t               row_index;
  logic [WallW-1:0]     row_walls;
  coord_t               cell_x;
  coord_t               cell_y;

  // config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reveal_all_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      reveal_all_q <= cfg_data_i;
    end
  end

  // input word decode
  assign s_axis_tready_o = !walker_busy;
  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign row_index   = s_axis_tdata_i[RowIdxLsb +: CoordW];
  assign row_walls   = s_axis_tdata_i[WallsLsb +: WallW];
  assign load_row    = in_fire && (s_axis_tuser_i == FUNC_LOAD) &&
                       ({1'b0, row_index} < StepW'(GRID_SIZE));
  assign start_trace = in_fire && (s_axis_tuser_i == FUNC_TRACE);

  glos_wall_mem #(
    .GRID_SIZE(GRID_SIZE)
  ) u_wall_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (load_row),
    .wr_addr_i(row_index[AddrW-1:0]),
    .wr_data_i(row_walls[GRID_SIZE-1:0]),
    .rd_en_i  (cell_valid && cell_ready),
    .rd_addr_i(walk_cell.y[AddrW-1:0]),
    .rd_data_o(wall_row)
  );

  glos_walker #(
    .GRID_SIZE(GRID_SIZE)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_trace),
    .reveal_all_i(reveal_all_q),
    .origin_x_i  (s_axis_tdata_i[OrgXLsb +: CoordW]),
    .origin_y_i  (s_axis_tdata_i[OrgYLsb +: CoordW]),
    .target_x_i  (s_axis_tdata_i[TgtXLsb +: CoordW]),
    .target_y_i  (s_axis_tdata_i[TgtYLsb +: CoordW]),
    .busy_o      (walker_busy),
    .cell_valid_o(cell_valid),
    .cell_ready_i(cell_ready),
    .cell_o      (walk_cell)
  );

  glos_vis_out #(
    .GRID_SIZE(GRID_SIZE)
  ) u_vis_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_valid_i(cell_valid),
    .cell_ready_o(cell_ready),
    .cell_i      (walk_cell),
    .wall_row_i  (wall_row),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cell_x_o    (cell_x),
    .cell_y_o    (cell_y),
    .visible_o   (m_axis_tuser_o),
    .last_cell_o (m_axis_tlast_o)
  );

  // output word packing
  assign m_axis_tdata_o = {{(OutDataW - 2 * CoordW){1'b0}}, cell_y, cell_x};

endmodule
